// ----- sv/turnout_solenoid_scheduler_unit_macros.svh -----
// Assertion macros for the turnout solenoid scheduler checker
`ifndef TURNOUT_SOLENOID_SCHEDULER_UNIT_MACROS_SVH
`define TURNOUT_SOLENOID_SCHEDULER_UNIT_MACROS_SVH

// implication in the same cycle, off during reset
`define TSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle, off during reset
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication in the next cycle, checked through reset
`define TSS_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/tss_pkg.sv -----
// Shared types, constants and helpers of the turnout solenoid scheduler
`timescale 1ns / 1ps
package tss_pkg;

  localparam int QUEUE_DEPTH_DEF  = 64;
  localparam int NUM_SWITCHES_DEF = 22;

  localparam logic [15:0] SETTLE_RESET = 16'd250;

  localparam logic [7:0] BYTE_OFF      = 8'd32;
  localparam logic [7:0] BYTE_STRAIGHT = 8'd33;
  localparam logic [7:0] BYTE_CURVED   = 8'd34;

  localparam logic [7:0] ID_PLAIN_MIN = 8'd1;
  localparam logic [7:0] ID_PLAIN_MAX = 8'd18;
  localparam logic [7:0] ID_PAIR0_LO  = 8'd153;
  localparam logic [7:0] ID_PAIR1_HI  = 8'd156;
  localparam logic [4:0] SLOT_PAIR_BASE = 5'd18;

  typedef enum logic {
    FUNC_REQUEST = 1'b0,
    FUNC_TICK    = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    SHADOW_UNKNOWN  = 2'd0,
    SHADOW_STRAIGHT = 2'd1,
    SHADOW_CURVED   = 2'd2
  } shadow_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  turnout_number;
    logic        want_straight;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic       straight;
    logic [7:0] id;
    logic       paired;
  } row_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] slot;
  } slot_t;

  function automatic slot_t slot_of(input logic [7:0] id);
    slot_t s;
    s.ok   = 1'b0;
    s.slot = '0;
    if (id >= ID_PLAIN_MIN && id <= ID_PLAIN_MAX) begin
      s.ok   = 1'b1;
      s.slot = 5'(id - ID_PLAIN_MIN);
    end else if (id >= ID_PAIR0_LO && id <= ID_PAIR1_HI) begin
      s.ok   = 1'b1;
      s.slot = SLOT_PAIR_BASE + 5'(id - ID_PAIR0_LO);
    end
    return s;
  endfunction

endpackage

// ----- sv/turnout_solenoid_scheduler_unit.sv -----
// Turnout solenoid scheduler: command queue, shadow state and solenoid timing.
// An accepted item waits in the input register until the output can take its
// bytes; a tick that acts registers its first byte in the result register.
// A tick that sends a command fills both output slots and the input waits until
// the second byte moves up to the result register.
// Synchronous active-high reset empties the queue, clears shadow and solenoid.
`timescale 1ns / 1ps
module turnout_solenoid_scheduler_unit
  import tss_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        settle_we,
  input  logic [15:0] settle_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  localparam int ROWS = QUEUE_DEPTH / 2;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = $clog2(ROWS + 1);
  localparam int SW   = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

  logic [15:0] settle_ticks;
  logic        in_v;
  item_t       in_q;

  row_t        mem [ROWS];
  row_t        mem_q;
  logic        fwd;
  row_t        fwd_row;
  logic [RW-1:0] head, head_next, tail;
  logic        head_half, half_next;
  logic [CW-1:0] cmd_count;

  shadow_t     shadow [NUM_SWITCHES];
  logic        sol_on;
  logic [31:0] last_time;

  logic        res_valid, sec_valid;
  result_t     res_q, sec_q;

  logic        fire, is_req, legal, paired, full, push, settled;
  logic        off, cmd, partner_phase, emit_straight, upd_ok;
  slot_t       req_slot, upd_slot;
  shadow_t     want;
  logic [1:0]  need;
  logic [7:0]  emit_id;
  row_t        head_row, push_row;

  assign fire   = in_v && !sec_valid && (!res_valid || !result_stall);
  assign is_req = (in_q.func == FUNC_REQUEST);

  assign req_slot = slot_of(in_q.turnout_number);
  assign legal    = req_slot.ok && ({27'b0, req_slot.slot} < 32'(NUM_SWITCHES));
  assign want     = in_q.want_straight ? SHADOW_STRAIGHT : SHADOW_CURVED;
  assign paired   = (in_q.turnout_number >= ID_PAIR0_LO);
  assign need     = paired ? 2'd2 : 2'd1;
  assign full     = ({1'b0, cmd_count} + (CW+1)'(need)) > (CW+1)'(ROWS);
  assign push     = fire && is_req && legal && !full && (shadow[SW'(req_slot.slot)] != want);

  assign push_row.straight = in_q.want_straight;
  assign push_row.id       = in_q.turnout_number;
  assign push_row.paired   = paired;

  assign settled = (last_time + {16'b0, settle_ticks}) < in_q.now;

  assign head_row      = fwd ? fwd_row : mem_q;
  assign partner_phase = head_row.paired && !head_half;
  assign emit_id       = partner_phase ? (head_row.id[0] ? head_row.id + 8'd1 : head_row.id - 8'd1)
                                       : head_row.id;
  assign emit_straight = partner_phase ? !head_row.straight : head_row.straight;
  assign upd_slot      = slot_of(emit_id);
  assign upd_ok        = upd_slot.ok && ({27'b0, upd_slot.slot} < 32'(NUM_SWITCHES));

  assign off = fire && !is_req && sol_on && settled;
  assign cmd = fire && !is_req && !sol_on && (cmd_count != '0) && settled;

  assign item_stall   = in_v && !fire;
  assign result_valid = res_valid;
  assign result       = res_q;

  always_comb begin
    head_next = head;
    half_next = head_half;
    if (cmd) begin
      if (partner_phase) begin
        half_next = 1'b1;
      end else begin
        half_next = 1'b0;
        head_next = (head == RW'(ROWS - 1)) ? '0 : head + RW'(1);
      end
    end
  end

  // queue storage with registered read at the next head
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_row;
    end
    mem_q   <= mem[head_next];
    fwd     <= push && (tail == head_next);
    fwd_row <= push_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks <= SETTLE_RESET;
      in_v         <= 1'b0;
      head         <= '0;
      head_half    <= 1'b0;
      tail         <= '0;
      cmd_count    <= '0;
      sol_on       <= 1'b0;
      last_time    <= '0;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        shadow[i] <= SHADOW_UNKNOWN;
      end
    end else begin
      if (settle_we) begin
        settle_ticks <= settle_data;
      end
      if (item_valid && !item_stall) begin
        in_v <= 1'b1;
        in_q <= item;
      end else if (fire) begin
        in_v <= 1'b0;
      end
      head      <= head_next;
      head_half <= half_next;
      if (push) begin
        tail      <= (tail == RW'(ROWS - 1)) ? '0 : tail + RW'(1);
        cmd_count <= cmd_count + CW'(need);
      end else if (cmd) begin
        cmd_count <= cmd_count - CW'(1);
      end
      if (off) begin
        sol_on    <= 1'b0;
        last_time <= in_q.now;
      end else if (cmd) begin
        sol_on    <= 1'b1;
        last_time <= in_q.now;
        if (upd_ok) begin
          shadow[SW'(upd_slot.slot)] <= emit_straight ? SHADOW_STRAIGHT : SHADOW_CURVED;
        end
      end
    end
  end

  // two-slot output: hold the turnout byte behind the direction byte
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else begin
      if (off || cmd) begin
        res_valid         <= 1'b1;
        res_q.tx_byte     <= off ? BYTE_OFF : (emit_straight ? BYTE_STRAIGHT : BYTE_CURVED);
        res_q.last_of_run <= off;
        sec_valid         <= cmd;
        sec_q.tx_byte     <= emit_id;
        sec_q.last_of_run <= 1'b1;
      end else if (res_valid && !result_stall) begin
        res_valid <= sec_valid;
        res_q     <= sec_q;
        sec_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/tss_checker.sv -----
// Port-level assertions for the turnout solenoid scheduler, bound to the top level
`timescale 1ns / 1ps
`include "turnout_solenoid_scheduler_unit_macros.svh"
module tss_checker
  import tss_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  `TSS_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid, "result dropped while stalled")
  `TSS_ASSERT_NEXT(a_res_stable, result_valid && result_stall, $stable(result), "stalled result changed")
  `TSS_ASSERT_RST(a_rst_quiet, rst, !result_valid, "result shown after reset")
  `TSS_ASSERT_NOW(a_dir_first, result_valid && !result.last_of_run, result.tx_byte == BYTE_STRAIGHT || result.tx_byte == BYTE_CURVED, "non-final byte is not a direction byte")
  `TSS_ASSERT_NOW(a_off_last, result_valid && result.tx_byte == BYTE_OFF, result.last_of_run, "switch-off byte not final")

endmodule

bind turnout_solenoid_scheduler_unit tss_checker u_tss_checker (.*);

// ----- bench/tb.sv -----
// Self-checking bench for the turnout solenoid scheduler: directed and random requests and ticks
`timescale 1ns / 1ps
module tb;
  import tss_pkg::*;

  localparam logic [7:0] ID_PAIR0_HI = 8'd154;
  localparam logic [7:0] ID_PAIR1_LO = 8'd155;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 500;
  localparam int PHASE_ITEMS  = 250;
  localparam int FILL_BURST   = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        settle_we = 1'b0;
  logic [15:0] settle_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;

  turnout_solenoid_scheduler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .settle_we    (settle_we),
    .settle_data  (settle_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #6 clk = ~clk;

  logic [15:0] settle_cfg = SETTLE_RESET;
  logic [7:0]  cmd_fifo[$];
  shadow_t     shadow_pos[NUM_SWITCHES_DEF] = '{default: SHADOW_UNKNOWN};
  logic        solenoid_hot = 1'b0;
  logic [31:0] last_action = '0;
  result_t     bytes_due[$];

  item_t       pending_items[$];
  int          items_queued = 0;
  int          items_accepted = 0;
  int          requests_sent = 0;
  int          ticks_sent = 0;
  int          results_checked = 0;
  int          commands_due = 0;
  int          offs_due = 0;
  int          mismatch_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  int          hold_at = 32'h7fff_ffff;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;
  int          cycle_count = 0;
  logic [31:0] clock_now = '0;
  logic [15:0] settle_now = SETTLE_RESET;

  function automatic int shadow_slot(logic [7:0] id);
    int slot;
    slot = -1;
    if (id >= ID_PLAIN_MIN && id <= ID_PLAIN_MAX) begin
      slot = int'(id - ID_PLAIN_MIN);
    end else if (id >= ID_PAIR0_LO && id <= ID_PAIR1_HI) begin
      slot = int'(id - ID_PAIR0_LO) + int'(SLOT_PAIR_BASE);
    end
    if (slot >= NUM_SWITCHES_DEF) begin
      slot = -1;
    end
    return slot;
  endfunction

  function automatic bit has_settled(logic [31:0] stamp);
    logic [31:0] limit;
    limit = last_action + {16'd0, settle_cfg};
    return limit < stamp;
  endfunction

  task automatic queue_command(logic [7:0] id, logic straight);
    cmd_fifo.push_back(straight ? BYTE_STRAIGHT : BYTE_CURVED);
    cmd_fifo.push_back(id);
  endtask

  task automatic schedule_step(item_t it);
    int         slot;
    int         need;
    shadow_t    want;
    logic [7:0] dir_byte;
    logic [7:0] id_byte;
    if (it.func == FUNC_REQUEST) begin
      slot = shadow_slot(it.turnout_number);
      if (slot < 0) return;
      want = it.want_straight ? SHADOW_STRAIGHT : SHADOW_CURVED;
      if (shadow_pos[slot] == want) return;
      need = (it.turnout_number >= ID_PAIR0_LO) ? 4 : 2;
      if (cmd_fifo.size() + need > QUEUE_DEPTH_DEF) return;
      case (it.turnout_number)
        ID_PAIR0_LO: queue_command(ID_PAIR0_HI, !it.want_straight);
        ID_PAIR0_HI: queue_command(ID_PAIR0_LO, !it.want_straight);
        ID_PAIR1_LO: queue_command(ID_PAIR1_HI, !it.want_straight);
        ID_PAIR1_HI: queue_command(ID_PAIR1_LO, !it.want_straight);
        default: ;
      endcase
      queue_command(it.turnout_number, it.want_straight);
    end else if (solenoid_hot) begin
      if (has_settled(it.now)) begin
        solenoid_hot = 1'b0;
        last_action = it.now;
        bytes_due.push_back('{tx_byte: BYTE_OFF, last_of_run: 1'b1});
        offs_due++;
      end
    end else if (cmd_fifo.size() >= 2 && has_settled(it.now)) begin
      dir_byte = cmd_fifo.pop_front();
      id_byte = cmd_fifo.pop_front();
      slot = shadow_slot(id_byte);
      if (slot >= 0) begin
        shadow_pos[slot] = (dir_byte == BYTE_STRAIGHT) ? SHADOW_STRAIGHT : SHADOW_CURVED;
      end
      bytes_due.push_back('{tx_byte: dir_byte, last_of_run: 1'b0});
      bytes_due.push_back('{tx_byte: id_byte, last_of_run: 1'b1});
      last_action = it.now;
      solenoid_hot = 1'b1;
      commands_due++;
    end
  endtask

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("ERROR %0t: %s", $time, what);
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (bytes_due.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %0d", got.tx_byte));
      return;
    end
    want = bytes_due.pop_front();
    results_checked++;
    if (got.tx_byte !== want.tx_byte) begin
      report_mismatch($sformatf("tx_byte got %0d, expected %0d", got.tx_byte, want.tx_byte));
    end
    if (got.last_of_run !== want.last_of_run) begin
      report_mismatch($sformatf("last_of_run got %0b, expected %0b (byte %0d)",
                                got.last_of_run, want.last_of_run, want.tx_byte));
    end
  endtask

  task automatic add_request(logic [7:0] id, logic straight);
    item_t it;
    it.func = FUNC_REQUEST;
    it.turnout_number = id;
    it.want_straight = straight;
    it.now = $urandom;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_tick(logic [31:0] stamp);
    item_t it;
    it.func = FUNC_TICK;
    it.turnout_number = 8'($urandom);
    it.want_straight = 1'($urandom);
    it.now = stamp;
    clock_now = stamp;
    pending_items.push_back(it);
    items_queued++;
  endtask

  function automatic logic [7:0] legal_id();
    int pick;
    pick = $urandom_range(0, 21);
    return (pick < 18) ? 8'(pick + 1) : 8'(int'(ID_PAIR0_LO) + pick - 18);
  endfunction

  task automatic add_traffic(int count);
    int roll;
    int added;
    added = 0;
    while (added < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        add_request(legal_id(), 1'($urandom));
        added++;
      end else if (roll < 75) begin
        add_tick(clock_now + {16'd0, settle_now} + 32'($urandom_range(1, 40)));
        added++;
      end else if (roll < 83) begin
        add_tick(clock_now + 32'($urandom_range(0, settle_now)));
        added++;
      end else if (roll < 90) begin
        add_request(8'($urandom), 1'($urandom));
        added++;
      end else if (roll < 94) begin
        add_tick($urandom);
        added++;
      end else if (roll < 96) begin
        add_tick(32'hFFFF_FF00 + 32'($urandom_range(0, 255)));
        added++;
      end else begin
        // overfill the command queue
        repeat (FILL_BURST) add_request(legal_id(), 1'($urandom));
        added += FILL_BURST;
      end
    end
  endtask

  task automatic write_settle(logic [15:0] value);
    @(posedge clk);
    settle_we <= 1'b1;
    settle_data <= value;
    @(posedge clk);
    settle_we <= 1'b0;
    settle_now = value;
  endtask

  task automatic wait_quiet();
    while (items_accepted != items_queued || bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (settle_we) settle_cfg = settle_data;
      if (item_valid && !item_stall) begin
        schedule_step(item);
        items_accepted++;
        if (item.func == FUNC_TICK) ticks_sent++;
        else requests_sent++;
      end
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          item_valid <= 1'b0;
          send_gap--;
        end else if (pending_items.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
          item_valid <= 1'b0;
          send_gap = $urandom_range(0, 17);
        end else if (pending_items.size() != 0) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) check_result(result);
      if (!hold_done && items_accepted >= hold_at) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (recv_gap > 0) begin
        result_stall <= 1'b1;
        recv_gap--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        recv_gap = $urandom_range(0, 17);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_tick(32'd100);
    add_request(8'd0, 1'b1);
    add_request(8'd19, 1'b0);
    add_request(8'd152, 1'b1);
    add_request(8'd157, 1'b0);
    add_request(8'd255, 1'b1);
    add_request(8'd1, 1'b1);
    add_tick(32'd200);
    add_tick(32'd251);
    add_tick(32'd400);
    add_tick(32'd502);
    add_request(8'd1, 1'b1);
    add_request(8'd18, 1'b0);
    add_request(ID_PAIR0_LO, 1'b1);
    add_request(ID_PAIR1_HI, 1'b0);
    for (int k = 1; k <= 10; k++) begin
      add_tick(32'd502 + 32'(k * 1000));
    end
    wait_quiet();

    write_settle(16'd0);
    add_traffic(PHASE_ITEMS);
    wait_quiet();

    write_settle(16'hFFFF);
    add_traffic(PHASE_ITEMS);
    wait_quiet();

    write_settle(16'($urandom_range(2, 500)));
    hold_at = items_queued + 60;
    add_traffic(PHASE_ITEMS);
    wait_quiet();

    write_settle(16'd1);
    add_traffic(PHASE_ITEMS);
    wait_quiet();

    write_settle(16'($urandom_range(2, 2000)));
    add_traffic(PHASE_ITEMS);
    wait_quiet();

    calm = 1'b1;
    write_settle(SETTLE_RESET);
    add_traffic(PHASE_ITEMS);
    wait_quiet();

    $display("Run drove %0d turnout requests and %0d ticks over six settle times incl. 0 and 65535.",
             requests_sent, ticks_sent);
    $display("Checked %0d bytes: %0d commands and %0d solenoid switch-offs.",
             results_checked, commands_due, offs_due);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- turnout_solenoid_scheduler_unit.f -----
+incdir+sv
sv/tss_pkg.sv
sv/turnout_solenoid_scheduler_unit.sv
sv/tss_checker.sv
bench/tb.sv
